// File: hw/rtl/psgw_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the PNG grayscale writer.
// No dependencies; every other file imports this package.
package psgw_pkg;

  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned RAW_W       = 25;
  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned BLOCK_BYTES = 65535;
  localparam int unsigned ADLER_MOD   = 65521;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] IEND_CRC    = 32'hAE426082;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic       is_start;
    logic [7:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [RAW_W-1:0] raw_len;
    logic [31:0]      idat_len;
  } geom_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/psgw_front.sv
// Front end: input holding register that classifies each word as start or pixel.
// Depends on psgw_pkg; feeds psgw_queue.
module psgw_front import psgw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_pixel,
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       push_cmd,
  output logic       hold_valid
);

  cmd_t hold;

  assign push     = hold_valid && !q_stat.full;
  assign in_ready = !hold_valid || !q_stat.full;
  assign push_cmd = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold.is_start <= (op_t'(in_op) == OP_START);
      hold.pixel    <= in_pixel;
    end
  end

endmodule

// File: hw/rtl/psgw_queue.sv
// Short command queue between the front end and the byte sequencer.
// Depends on psgw_pkg.
module psgw_queue import psgw_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/psgw_back.sv
// Back end: byte sequencer with running CRC-32, Adler-32 and the output register.
// Depends on psgw_pkg; pops commands from psgw_queue.
module psgw_back import psgw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  geom_t      geom,
  input  q_stat_t    q_stat,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_eof
);

  localparam logic [5:0] START_LAST = 6'd42;
  localparam logic [5:0] HDR_LAST   = 6'd4;
  localparam logic [5:0] FIN_LAST   = 6'd19;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_HDR, PH_DATA, PH_FIN
  } phase_t;

  phase_t           phase, phase_next;
  logic [5:0]       idx, idx_next;
  logic             started, started_next;
  logic [31:0]      crc, crc_next;
  logic [31:0]      ihc, ihc_next;
  logic [15:0]      alow, alow_next;
  logic [15:0]      ahigh, ahigh_next;
  logic [RAW_W-1:0] rpos, rpos_next;
  logic [15:0]      boff, boff_next;
  logic [CNT_W-1:0] col, col_next;
  logic [CNT_W-1:0] row, row_next;
  logic [7:0]       raw_val, raw_val_next;
  logic [7:0]       pix, pix_next;
  logic             pend, pend_next;

  logic             out_free, emit, done;
  logic [7:0]       ebyte;
  logic             elast, eeof;
  logic [RAW_W-1:0] rem;
  logic [15:0]      blk_n;
  logic             blk_final;
  logic [16:0]      lo_sum, hi_sum;
  logic [15:0]      lo_new, hi_new;
  logic [16:0]      boff_inc;
  logic [CNT_W:0]   col_inc, row_inc;

  assign out_free = !out_valid || out_ready;
  assign emit     = (phase != PH_IDLE) && out_free;

  // stored block length for the block that begins at rpos
  assign rem       = (geom.raw_len > rpos) ? geom.raw_len - rpos : '0;
  assign blk_n     = (rem > RAW_W'(BLOCK_BYTES)) ? 16'(BLOCK_BYTES) : rem[15:0];
  assign blk_final = ({1'b0, rpos} + {10'd0, blk_n}) >= {1'b0, geom.raw_len};

  assign lo_sum   = {1'b0, alow} + {9'd0, raw_val};
  assign lo_new   = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
  assign hi_sum   = {1'b0, ahigh} + {1'b0, lo_new};
  assign hi_new   = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];
  assign boff_inc = {1'b0, boff} + 17'd1;
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;

  always_comb begin
    phase_next   = phase;
    idx_next     = idx;
    started_next = started;
    crc_next     = crc;
    ihc_next     = ihc;
    alow_next    = alow;
    ahigh_next   = ahigh;
    rpos_next    = rpos;
    boff_next    = boff;
    col_next     = col;
    row_next     = row;
    raw_val_next = raw_val;
    pix_next     = pix;
    pend_next    = pend;
    ebyte        = '0;
    elast        = 1'b0;
    eeof         = 1'b0;
    done         = 1'b0;
    pop          = 1'b0;

    if (emit) begin
      unique case (phase)
        PH_START: begin
          case (idx) inside
            6'd0:         ebyte = 8'd137;
            6'd1:         ebyte = 8'h50;
            6'd2:         ebyte = 8'h4E;
            6'd3:         ebyte = 8'h47;
            6'd4:         ebyte = 8'h0D;
            6'd5:         ebyte = 8'h0A;
            6'd6:         ebyte = 8'h1A;
            6'd7:         ebyte = 8'h0A;
            6'd11:        ebyte = 8'd13;
            6'd12, 6'd37: ebyte = 8'h49;
            6'd13:        ebyte = 8'h48;
            6'd14:        ebyte = 8'h44;
            6'd15:        ebyte = 8'h52;
            6'd18:        ebyte = {3'd0, geom.w[12:8]};
            6'd19:        ebyte = geom.w[7:0];
            6'd22:        ebyte = {3'd0, geom.h[12:8]};
            6'd23:        ebyte = geom.h[7:0];
            6'd24:        ebyte = 8'd8;
            6'd29:        ebyte = ~ihc[31:24];
            6'd30:        ebyte = ~ihc[23:16];
            6'd31:        ebyte = ~ihc[15:8];
            6'd32:        ebyte = ~ihc[7:0];
            6'd33:        ebyte = geom.idat_len[31:24];
            6'd34:        ebyte = geom.idat_len[23:16];
            6'd35:        ebyte = geom.idat_len[15:8];
            6'd36:        ebyte = geom.idat_len[7:0];
            6'd38:        ebyte = 8'h44;
            6'd39:        ebyte = 8'h41;
            6'd40:        ebyte = 8'h54;
            6'd41:        ebyte = 8'h78;
            6'd42:        ebyte = 8'h01;
            default:      ebyte = 8'h00;
          endcase
          if (idx >= 6'd12 && idx <= 6'd28) begin
            ihc_next = crc_byte(ihc, ebyte);
          end
          if (idx >= 6'd37) begin
            crc_next = crc_byte(crc, ebyte);
          end
          idx_next = idx + 1'b1;
          if (idx == START_LAST) begin
            elast = 1'b1;
            done  = 1'b1;
          end
        end
        PH_HDR: begin
          case (idx)
            6'd0:    ebyte = {7'd0, blk_final};
            6'd1:    ebyte = blk_n[7:0];
            6'd2:    ebyte = blk_n[15:8];
            6'd3:    ebyte = ~blk_n[7:0];
            default: ebyte = ~blk_n[15:8];
          endcase
          crc_next = crc_byte(crc, ebyte);
          idx_next = idx + 1'b1;
          if (idx == HDR_LAST) begin
            phase_next = PH_DATA;
            idx_next   = '0;
          end
        end
        PH_DATA: begin
          ebyte      = raw_val;
          crc_next   = crc_byte(crc, ebyte);
          alow_next  = lo_new;
          ahigh_next = hi_new;
          rpos_next  = rpos + 1'b1;
          boff_next  = (boff_inc >= 17'(BLOCK_BYTES)) ? '0 : boff_inc[15:0];
          if (pend) begin
            raw_val_next = pix;
            pend_next    = 1'b0;
            phase_next   = (boff_next == '0) ? PH_HDR : PH_DATA;
            idx_next     = '0;
          end else if (col_inc >= geom.w) begin
            col_next = '0;
            if (row_inc >= geom.h) begin
              row_next     = '0;
              started_next = 1'b0;
              phase_next   = PH_FIN;
              idx_next     = '0;
            end else begin
              row_next = row_inc[CNT_W-1:0];
              elast    = 1'b1;
              done     = 1'b1;
            end
          end else begin
            col_next = col_inc[CNT_W-1:0];
            elast    = 1'b1;
            done     = 1'b1;
          end
        end
        PH_FIN: begin
          case (idx)
            6'd0:    ebyte = ahigh[15:8];
            6'd1:    ebyte = ahigh[7:0];
            6'd2:    ebyte = alow[15:8];
            6'd3:    ebyte = alow[7:0];
            6'd4:    ebyte = ~crc[31:24];
            6'd5:    ebyte = ~crc[23:16];
            6'd6:    ebyte = ~crc[15:8];
            6'd7:    ebyte = ~crc[7:0];
            6'd12:   ebyte = 8'h49;
            6'd13:   ebyte = 8'h45;
            6'd14:   ebyte = 8'h4E;
            6'd15:   ebyte = 8'h44;
            6'd16:   ebyte = IEND_CRC[31:24];
            6'd17:   ebyte = IEND_CRC[23:16];
            6'd18:   ebyte = IEND_CRC[15:8];
            6'd19:   ebyte = IEND_CRC[7:0];
            default: ebyte = 8'h00;
          endcase
          if (idx < 6'd4) begin
            crc_next = crc_byte(crc, ebyte);
          end
          idx_next = idx + 1'b1;
          if (idx == FIN_LAST) begin
            elast = 1'b1;
            eeof  = 1'b1;
            done  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // take the next command as soon as the current one delivers its last byte
    if (phase == PH_IDLE || done) begin
      phase_next = PH_IDLE;
      if (!q_stat.empty) begin
        pop = 1'b1;
        if (head.is_start) begin
          phase_next   = PH_START;
          idx_next     = '0;
          started_next = 1'b1;
          crc_next     = '1;
          ihc_next     = '1;
          alow_next    = 16'd1;
          ahigh_next   = '0;
          rpos_next    = '0;
          boff_next    = '0;
          col_next     = '0;
          row_next     = '0;
        end else if (started_next) begin
          pix_next     = head.pixel;
          pend_next    = (col_next == '0);
          raw_val_next = (col_next == '0) ? 8'h00 : head.pixel;
          phase_next   = (boff_next == '0) ? PH_HDR : PH_DATA;
          idx_next     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      idx       <= '0;
      started   <= 1'b0;
      crc       <= '1;
      alow      <= 16'd1;
      ahigh     <= '0;
      rpos      <= '0;
      boff      <= '0;
      col       <= '0;
      row       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      idx       <= idx_next;
      started   <= started_next;
      crc       <= crc_next;
      alow      <= alow_next;
      ahigh     <= ahigh_next;
      rpos      <= rpos_next;
      boff      <= boff_next;
      col       <= col_next;
      row       <= row_next;
      pend      <= pend_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
    ihc     <= ihc_next;
    raw_val <= raw_val_next;
    pix     <= pix_next;
    if (out_free) begin
      out_byte <= ebyte;
      out_last <= elast;
      out_eof  <= eeof;
    end
  end

endmodule

// File: hw/rtl/png_stored_grayscale_writer_unit.sv
// Top level of the stored-deflate PNG writer for 8-bit grayscale images.
// Depends on psgw_pkg, psgw_front, psgw_queue and psgw_back.
//
//   channel   | dir | handshake               | contents
//   s_axis    | in  | tvalid/tready           | tdata = pixel, tuser = op (0 start, 1 pixel)
//   m_axis    | out | tvalid/tready           | tdata = file byte, tlast = last of word,
//             |     |                         | tuser = end of file
//   cfg       | in  | cfg_we, no back-pressure| index 0 image width, 1 image height
//
// One output byte per cycle while the output side takes them and commands are queued; a
// pixel inside a row gives one byte, a row start two, a block start five more, a start
// word 43 and the last pixel of an image 20 more. The byte sequencer in psgw_back sets
// this rate; the queue lets the input side run ahead by up to QUEUE_DEPTH + 1 words while
// bytes wait. Reset is synchronous, no clearing pass. A stalled output holds its byte and
// stalls the sequencer; a full queue with a word held in front drops s_axis_tready.
module png_stored_grayscale_writer_unit import psgw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel
  input  logic             s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // [0] end_of_file
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [DIM_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [27:0]      prod;
  logic [RAW_W-1:0] raw_len;
  logic [25:0]      blk_x;
  logic [25:0]      blk_q;
  logic [9:0]       nblk;
  logic [31:0]      idat_len;
  geom_t            geom;

  q_stat_t q_stat;
  logic    push, pop, hold_valid;
  cmd_t    push_cmd, head;

  // Hold the clamped dimensions; IHDR carries the clamped value.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_WIDTH:  width_reg  <= clamp_dim(cfg_wdata);
        REG_HEIGHT: height_reg <= clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Raw stream length, then block count, then IDAT length are each registered in turn behind
  // the registers. Block count is ceil(raw/65535) via the x + (x >> 16) + 1 identity.
  assign prod  = (28'(width_reg) + 28'd1) * 28'(height_reg);
  assign blk_x = 26'(raw_len) + 26'(BLOCK_BYTES - 1);
  assign blk_q = (blk_x + (blk_x >> 16) + 26'd1) >> 16;

  always_ff @(posedge clk) begin
    raw_len  <= prod[RAW_W-1:0];
    nblk     <= blk_q[9:0];
    idat_len <= 32'd6 + 32'(nblk) * 32'd5 + 32'(raw_len);
  end

  assign geom.w        = width_reg;
  assign geom.h        = height_reg;
  assign geom.raw_len  = raw_len;
  assign geom.idat_len = idat_len;

  psgw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_pixel   (s_axis_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_cmd   (push_cmd),
    .hold_valid (hold_valid)
  );

  psgw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  psgw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_eof   (m_axis_tuser)
  );

  // end of file only ever falls on the last byte of a word
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end_of_file without tlast");

  // an accepted word lands in the front holding register
  a_front_load: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> hold_valid)
    else $error("accepted word lost in front end");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule
